// File: hw/rtl/quadratic_bezier_point_generator_top_defines.svh
// Assertion macros used by the checker of the Bezier point generator.
`ifndef QUADRATIC_BEZIER_POINT_GENERATOR_TOP_DEFINES_SVH
`define QUADRATIC_BEZIER_POINT_GENERATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle; ignored while in reset.
`define QB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qbez assertion failed");

// Consequent must hold in the next cycle; ignored while in reset.
`define QB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qbez assertion failed");

// Checked on every edge, reset included.
`define QB_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qbez assertion failed");

`endif

// File: hw/rtl/qbez_pkg.sv
// Shared types, constants and fixed-point helpers of the Bezier point generator.
package qbez_pkg;

  localparam int STEPS   = 64;
  localparam int SB      = $clog2(STEPS);
  localparam int COORD_W = 16;
  localparam int PW      = COORD_W + SB + 2;

  localparam int QDEPTH  = 2;
  localparam int QPW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam int ODEPTH  = 8;
  localparam int OPW     = $clog2(ODEPTH);
  localparam int OCW     = $clog2(ODEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PW-1:0]      prod_t;

  typedef struct packed {
    coord_t ha_x;
    coord_t ha_y;
    coord_t b_x;
    coord_t b_y;
    coord_t hb_x;
    coord_t hb_y;
  } curve_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // floor((p + q) / 2)
  function automatic coord_t midpoint(input coord_t p, input coord_t q);
    logic signed [COORD_W:0] s;
    s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
    return coord_t'(s[COORD_W:1]);
  endfunction

  // k * (q - p), exact
  function automatic prod_t mul_k(input logic [SB-1:0] k, input coord_t p, input coord_t q);
    logic signed [COORD_W:0] diff;
    prod_t kk;
    prod_t dd;
    diff = {q[COORD_W-1], q} - {p[COORD_W-1], p};
    kk   = PW'($signed({1'b0, k}));
    dd   = PW'(diff);
    return kk * dd;
  endfunction

  // p + floor(prod / STEPS); stays between the two end points
  function automatic coord_t add_shift(input coord_t p, input prod_t prod);
    prod_t s;
    s = PW'(p) + (prod >>> SB);
    return coord_t'(s[COORD_W-1:0]);
  endfunction

endpackage

// File: hw/rtl/quadratic_bezier_point_generator_top.sv
// Top level of the quadratic Bezier point generator.
//
//   channel   handshake       payload
//   input     push / full     point_a_x .. point_c_y  (one curve)
//   result    empty / pop     out_x, out_y, last_point (64 per curve)
//
// The point generator loads a curve from the queue, then gives one point per cycle
// while the result side has room for it.
// The front end and a 2-deep curve queue take new curves while a curve is stepped.
// A stalled result side stops the stepper once the points held in the 8-entry
// result FIFO and in the three pipeline stages reach eight; nothing is dropped.
// rst clears all control state.
module quadratic_bezier_point_generator_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  qbez_pkg::coord_t point_a_x,
  input  qbez_pkg::coord_t point_a_y,
  input  qbez_pkg::coord_t point_b_x,
  input  qbez_pkg::coord_t point_b_y,
  input  qbez_pkg::coord_t point_c_x,
  input  qbez_pkg::coord_t point_c_y,
  output logic             empty,
  input  logic             pop,
  output qbez_pkg::coord_t out_x,
  output qbez_pkg::coord_t out_y,
  output logic             last_point
);
  import qbez_pkg::*;

  logic   fq_push;
  curve_t fq_data;
  logic   fq_full;
  logic   qb_pop;
  curve_t qb_data;
  logic   qb_empty;

  qbez_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .point_a_x (point_a_x),
    .point_a_y (point_a_y),
    .point_b_x (point_b_x),
    .point_b_y (point_b_y),
    .point_c_x (point_c_x),
    .point_c_y (point_c_y),
    .q_push    (fq_push),
    .q_data    (fq_data),
    .q_full    (fq_full)
  );

  qbez_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (qb_pop),
    .rdata (qb_data),
    .empty (qb_empty)
  );

  qbez_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (qb_empty),
    .q_data     (qb_data),
    .q_pop      (qb_pop),
    .empty      (empty),
    .pop        (pop),
    .out_x      (out_x),
    .out_y      (out_y),
    .last_point (last_point)
  );

endmodule

// File: hw/rtl/qbez_front.sv
// Front end: takes a point triple, forms the two midpoints, hands a curve to the queue.
module qbez_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  qbez_pkg::coord_t point_a_x,
  input  qbez_pkg::coord_t point_a_y,
  input  qbez_pkg::coord_t point_b_x,
  input  qbez_pkg::coord_t point_b_y,
  input  qbez_pkg::coord_t point_c_x,
  input  qbez_pkg::coord_t point_c_y,
  output logic            q_push,
  output qbez_pkg::curve_t q_data,
  input  logic            q_full
);
  import qbez_pkg::*;

  logic   hold_valid;
  curve_t hold;
  logic   accept;

  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign q_push = hold_valid && !q_full;
  assign q_data = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.ha_x <= midpoint(point_a_x, point_b_x);
      hold.ha_y <= midpoint(point_a_y, point_b_y);
      hold.b_x  <= point_b_x;
      hold.b_y  <= point_b_y;
      hold.hb_x <= midpoint(point_b_x, point_c_x);
      hold.hb_y <= midpoint(point_b_y, point_c_y);
    end
  end

endmodule

// File: hw/rtl/qbez_queue.sv
// Short curve queue between the front end and the point generator.
module qbez_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qbez_pkg::curve_t wdata,
  output logic             full,
  input  logic             pop,
  output qbez_pkg::curve_t rdata,
  output logic             empty
);
  import qbez_pkg::*;

  curve_t           mem [QDEPTH];
  logic [QPW-1:0]   wptr;
  logic [QPW-1:0]   rptr;
  logic [QCW-1:0]   cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == QCW'(QDEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      cnt <= cnt + QCW'(do_push) - QCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// File: hw/rtl/qbez_back.sv
// Back end: steps t over one curve, three-stage de Casteljau pipeline, result FIFO.
module qbez_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  qbez_pkg::curve_t q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output qbez_pkg::coord_t out_x,
  output qbez_pkg::coord_t out_y,
  output logic             last_point
);
  import qbez_pkg::*;

  back_state_t    state;
  back_state_t    state_next;
  logic [SB-1:0]  k;
  curve_t         cur;
  logic           issue_ok;
  logic           issue;
  logic           issue_last;

  // stage 1: first-level products
  logic           s1v, s1last;
  logic [SB-1:0]  s1k;
  coord_t         s1_ha_x, s1_ha_y, s1_b_x, s1_b_y;
  prod_t          s1_p0x, s1_p0y, s1_p1x, s1_p1y;
  // stage 2: first-level points
  logic           s2v, s2last;
  logic [SB-1:0]  s2k;
  coord_t         s2_d0x, s2_d0y, s2_d1x, s2_d1y;
  // stage 3: second-level product
  logic           s3v, s3last;
  coord_t         s3_d0x, s3_d0y;
  prod_t          s3_px, s3_py;

  // result FIFO
  coord_t         of_x [ODEPTH];
  coord_t         of_y [ODEPTH];
  logic           of_l [ODEPTH];
  logic [OPW-1:0] owptr, orptr;
  logic [OCW-1:0] ocnt;
  logic [OCW:0]   room_need;
  logic           do_pop;

  // never issue a step unless the FIFO has a slot for it and for all in flight
  always_comb begin
    room_need = (OCW+1)'(ocnt) + (OCW+1)'(s1v) + (OCW+1)'(s2v) + (OCW+1)'(s3v)
                + (OCW+1)'(1);
    issue_ok  = (room_need <= (OCW+1)'(ODEPTH));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = BK_RUN;
      end
      BK_RUN: begin
        if (issue_ok && (k == SB'(STEPS - 1))) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = !q_empty;
      BK_RUN:  issue = issue_ok;
      default: begin
        q_pop = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  assign issue_last = (k == SB'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        k <= '0;
      end else if (issue) begin
        k <= issue_last ? '0 : k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
    end else begin
      s1v <= issue;
      s2v <= s1v;
      s3v <= s2v;
    end
  end

  always_ff @(posedge clk) begin
    s1last  <= issue_last;
    s1k     <= k;
    s1_ha_x <= cur.ha_x;
    s1_ha_y <= cur.ha_y;
    s1_b_x  <= cur.b_x;
    s1_b_y  <= cur.b_y;
    s1_p0x  <= mul_k(k, cur.ha_x, cur.b_x);
    s1_p0y  <= mul_k(k, cur.ha_y, cur.b_y);
    s1_p1x  <= mul_k(k, cur.b_x, cur.hb_x);
    s1_p1y  <= mul_k(k, cur.b_y, cur.hb_y);

    s2last  <= s1last;
    s2k     <= s1k;
    s2_d0x  <= add_shift(s1_ha_x, s1_p0x);
    s2_d0y  <= add_shift(s1_ha_y, s1_p0y);
    s2_d1x  <= add_shift(s1_b_x, s1_p1x);
    s2_d1y  <= add_shift(s1_b_y, s1_p1y);

    s3last  <= s2last;
    s3_d0x  <= s2_d0x;
    s3_d0y  <= s2_d0y;
    s3_px   <= mul_k(s2k, s2_d0x, s2_d1x);
    s3_py   <= mul_k(s2k, s2_d0y, s2_d1y);
  end

  assign empty      = (ocnt == '0);
  assign do_pop     = pop && !empty;
  assign out_x      = of_x[orptr];
  assign out_y      = of_y[orptr];
  assign last_point = of_l[orptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= '0;
      orptr <= '0;
      ocnt  <= '0;
    end else begin
      if (s3v) owptr <= (owptr == OPW'(ODEPTH - 1)) ? '0 : owptr + 1'b1;
      if (do_pop) orptr <= (orptr == OPW'(ODEPTH - 1)) ? '0 : orptr + 1'b1;
      ocnt <= ocnt + OCW'(s3v) - OCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s3v) begin
      of_x[owptr] <= add_shift(s3_d0x, s3_px);
      of_y[owptr] <= add_shift(s3_d0y, s3_py);
      of_l[owptr] <= s3last;
    end
  end

endmodule

// File: hw/rtl/qbez_checker.sv
// Port-level checker for the Bezier point generator, bound to the top level.
`include "quadratic_bezier_point_generator_top_defines.svh"

module qbez_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input qbez_pkg::coord_t out_x,
  input qbez_pkg::coord_t out_y,
  input logic             last_point
);
  import qbez_pkg::*;

  logic          in_xfer;
  logic          out_xfer;
  logic [SB-1:0] seen;
  logic [3:0]    open_curves;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= '0;
      open_curves <= '0;
    end else begin
      if (out_xfer) seen <= last_point ? '0 : seen + 1'b1;
      open_curves <= open_curves + 4'(in_xfer) - 4'(out_xfer && last_point);
    end
  end

  `QB_ASSERT_ALWAYS(a_empty_after_reset, rst, empty)
  `QB_ASSERT_NOW(a_last_on_final_step, out_xfer, last_point == (seen == SB'(STEPS - 1)))
  `QB_ASSERT_NOW(a_no_result_without_curve, open_curves == '0, empty)
  `QB_ASSERT_NEXT(a_stall_holds, !empty && !pop,
                  !empty && $stable(out_x) && $stable(out_y) && $stable(last_point))

endmodule

bind quadratic_bezier_point_generator_top qbez_checker u_qbez_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_x      (out_x),
  .out_y      (out_y),
  .last_point (last_point)
);
